// ===== design/ptfb_pkg.sv =====
// Shared types and constants for the planar texture coordinate block.
package ptfb_pkg;

	localparam int CW   = 32;
	localparam int FRAC = 16;
	localparam int QW   = FRAC + 1;
	localparam int NW   = CW + FRAC + 1;
	localparam int SW   = $clog2(QW);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_NUMS,
		ST_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_clr;
		logic rd_en;
		logic num_ld;
		logic div_init;
		logic div_step;
		logic rd_next;
		logic run_end;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_idx;
	} sts_t;

endpackage

// ===== design/planar_texcoord_from_bbox.sv =====
// Top level of the bounding-box planar texture coordinate generator.
// Input channel (in_valid/in_stall): one mesh vertex per item, signed Q16.16
// pos_x and pos_y; last_vertex marks the final vertex of the mesh. Loading
// takes one item per cycle; vertices past MAX_VERTICES are dropped and flagged.
// After the last vertex the block stalls its input and emits one item per
// stored vertex on the output channel (out_valid/out_stall), in arrival order:
// unsigned Q1.16 tex_u and tex_v, zero_extent, capacity_exceeded, last_coord.
// Once the previous item is taken, each output item is produced by a registered
// read of the vertex store, a numerator load, a dividend load and 17 steps of
// the two restoring divider lanes that produce u and v one quotient bit a cycle.
// When the receiver stalls, the output item and its fields hold until taken;
// input is accepted again in the cycle after the final item of the run is taken.
// Reset clears the vertex count, the overflow flag and the sequencer; the
// vertex store needs no clearing since only entries written in the current
// mesh are read.
module planar_texcoord_from_bbox import ptfb_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               zero_extent,
	output logic               capacity_exceeded,
	output logic               last_coord
);

	cmd_t cmd;
	sts_t sts;

	ptfb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_vertex (last_vertex),
		.out_stall   (out_stall),
		.sts         (sts),
		.cmd         (cmd),
		.in_stall    (in_stall),
		.out_valid   (out_valid)
	);

	ptfb_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.pos_x             (pos_x),
		.pos_y             (pos_y),
		.tex_u             (tex_u),
		.tex_v             (tex_v),
		.zero_extent       (zero_extent),
		.capacity_exceeded (capacity_exceeded),
		.last_coord        (last_coord)
	);

endmodule

// ===== design/ptfb_div.sv =====
// Restoring divider lane: a rounded Q1.16 ratio, one quotient bit per step cycle.
module ptfb_div import ptfb_pkg::*; (
	input  logic          clk,
	input  logic          init,
	input  logic          step,
	input  logic [CW-1:0] num,
	input  logic [CW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [NW-1:0] dividend;
	logic [CW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quot_q;
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic          ge;

	assign dividend = {1'b0, num, {FRAC{1'b0}}} + NW'(den >> 1);
	assign trial    = {rem_q, low_q[QW-1]};
	assign diff     = trial - {1'b0, den};
	assign ge       = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= dividend[NW-1:QW];
			low_q <= dividend[QW-1:0];
		end else if (step) begin
			rem_q  <= ge ? diff[CW-1:0] : trial[CW-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign quot = quot_q;

endmodule

// ===== design/ptfb_datapath.sv =====
// Vertex store, bounding box, extents, divider lanes and result fields.
module ptfb_datapath import ptfb_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic [QW-1:0]      tex_u,
	output logic [QW-1:0]      tex_v,
	output logic               zero_extent,
	output logic               capacity_exceeded,
	output logic               last_coord
);

	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	logic [2*CW-1:0]      mem [MAX_VERTICES];
	logic [2*CW-1:0]      rd_data_q;
	logic [CNTW-1:0]      count_q;
	logic                 ovf_q;
	logic [AW-1:0]        rd_idx_q;
	logic signed [CW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [CW-1:0]        ext_x_q, ext_y_q;
	logic [CW-1:0]        num_x_q, num_y_q;
	logic                 full;
	logic signed [CW:0]   dx, dy, nx, ny;
	logic signed [CW-1:0] rd_x, rd_y;
	logic [QW-1:0]        quot_u, quot_v;

	assign full = count_q == CNTW'(MAX_VERTICES);
	assign rd_x = rd_data_q[2*CW-1:CW];
	assign rd_y = rd_data_q[CW-1:0];
	assign dx   = {max_x_q[CW-1], max_x_q} - {min_x_q[CW-1], min_x_q};
	assign dy   = {max_y_q[CW-1], max_y_q} - {min_y_q[CW-1], min_y_q};
	assign nx   = {max_x_q[CW-1], max_x_q} - {rd_x[CW-1], rd_x};
	assign ny   = {max_y_q[CW-1], max_y_q} - {rd_y[CW-1], rd_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.run_end) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNTW'(1);
				end
			end
			if (cmd.rd_clr) begin
				rd_idx_q <= '0;
			end else if (cmd.rd_next) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !full) begin
			mem[count_q[AW-1:0]] <= {pos_x, pos_y};
			if (count_q == '0) begin
				min_x_q <= pos_x;
				max_x_q <= pos_x;
				min_y_q <= pos_y;
				max_y_q <= pos_y;
			end else begin
				if (pos_x < min_x_q) min_x_q <= pos_x;
				if (pos_x > max_x_q) max_x_q <= pos_x;
				if (pos_y < min_y_q) min_y_q <= pos_y;
				if (pos_y > max_y_q) max_y_q <= pos_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_idx_q];
			ext_x_q   <= dx[CW-1:0];
			ext_y_q   <= dy[CW-1:0];
		end
		if (cmd.num_ld) begin
			num_x_q <= nx[CW-1:0];
			num_y_q <= ny[CW-1:0];
		end
	end

	ptfb_div u_div_u (
		.clk  (clk),
		.init (cmd.div_init),
		.step (cmd.div_step),
		.num  (num_x_q),
		.den  (ext_x_q),
		.quot (quot_u)
	);

	ptfb_div u_div_v (
		.clk  (clk),
		.init (cmd.div_init),
		.step (cmd.div_step),
		.num  (num_y_q),
		.den  (ext_y_q),
		.quot (quot_v)
	);

	assign tex_u             = (ext_x_q == '0) ? '0 : quot_u;
	assign tex_v             = (ext_y_q == '0) ? '0 : quot_v;
	assign zero_extent       = (ext_x_q == '0) || (ext_y_q == '0);
	assign capacity_exceeded = ovf_q;
	assign last_coord        = sts.last_idx;

	assign sts.last_idx = CNTW'(rd_idx_q) == (count_q - CNTW'(1));
	assign sts.div_done = 1'b0;

endmodule

// ===== design/ptfb_ctrl.sv =====
// Controller state machine sequencing loading, store reads, division and output.
module ptfb_ctrl import ptfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_vertex,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);

	state_t        state_q, state_d;
	logic [SW-1:0] step_q;
	logic          step_done;

	assign step_done = step_q == SW'(QW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && last_vertex) begin
					cmd.rd_clr = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_NUMS;
			end
			ST_NUMS: begin
				cmd.num_ld = 1'b1;
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_done || sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.last_idx) begin
						cmd.run_end = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for planar_texcoord_from_bbox with a mesh scoreboard.
module testbench;

	localparam int CAP    = 64;
	localparam int ITEMS  = 250;
	localparam int LIMIT  = 200000;
	localparam int SETTLE = 40;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_t;
	typedef enum int {AXIS_FULL, AXIS_NARROW, AXIS_FLAT} axis_mode_t;

	typedef struct {
		logic [16:0] u;
		logic [16:0] v;
		logic        zero;
		logic        over;
		logic        last;
	} texcoord_t;

	class texcoord_scoreboard;
		int                 errors;
		int                 cap;
		texcoord_t          coord_q[$];
		logic signed [31:0] mesh_x[$];
		logic signed [31:0] mesh_y[$];
		logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
		bit                 dropped;

		function new(int n);
			cap = n;
			errors = 0;
			dropped = 0;
		endfunction

		function logic [16:0] unit_ratio(longint num, longint den);
			if (den == 0)
				return '0;
			return 17'(((num << 16) + (den >> 1)) / den);
		endfunction

		function void note_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
			longint    span_x;
			longint    span_y;
			texcoord_t c;
			if (mesh_x.size() < cap) begin
				if (mesh_x.size() == 0) begin
					lo_x = x; hi_x = x; lo_y = y; hi_y = y;
				end else begin
					if (x < lo_x) lo_x = x;
					if (x > hi_x) hi_x = x;
					if (y < lo_y) lo_y = y;
					if (y > hi_y) hi_y = y;
				end
				mesh_x.insert(mesh_x.size(), x);
				mesh_y.insert(mesh_y.size(), y);
			end else begin
				dropped = 1;
			end
			if (!last)
				return;
			span_x = longint'(hi_x) - longint'(lo_x);
			span_y = longint'(hi_y) - longint'(lo_y);
			foreach (mesh_x[i]) begin
				c.u    = unit_ratio(longint'(hi_x) - longint'(mesh_x[i]), span_x);
				c.v    = unit_ratio(longint'(hi_y) - longint'(mesh_y[i]), span_y);
				c.zero = (span_x == 0) || (span_y == 0);
				c.over = dropped;
				c.last = (i == mesh_x.size() - 1);
				coord_q.insert(coord_q.size(), c);
			end
			mesh_x.delete();
			mesh_y.delete();
			dropped = 0;
		endfunction

		function void compare_field(string name, logic [16:0] exp_val, logic [16:0] act_val);
			if (act_val !== exp_val) begin
				$error("%s expected %0d got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_coord(logic [16:0] u, logic [16:0] v, logic zero, logic over,
			logic last);
			texcoord_t c;
			if (coord_q.size() == 0) begin
				$error("unexpected coordinate item u=%0d v=%0d", u, v);
				errors++;
				return;
			end
			c = coord_q.pop_front();
			compare_field("tex_u", c.u, u);
			compare_field("tex_v", c.v, v);
			compare_field("zero_extent", 17'(c.zero), 17'(zero));
			compare_field("capacity_exceeded", 17'(c.over), 17'(over));
			compare_field("last_coord", 17'(c.last), 17'(last));
		endfunction

		function int pending();
			return coord_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               last_vertex;
	logic               out_valid;
	logic               out_stall;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic               zero_extent;
	logic               capacity_exceeded;
	logic               last_coord;

	texcoord_scoreboard sb = new(CAP);
	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;

	planar_texcoord_from_bbox #(
		.MAX_VERTICES(CAP)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.last_vertex      (last_vertex),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tex_u            (tex_u),
		.tex_v            (tex_v),
		.zero_extent      (zero_extent),
		.capacity_exceeded(capacity_exceeded),
		.last_coord       (last_coord)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_coord(tex_u, tex_v, zero_extent, capacity_exceeded, last_coord);
	end

	// Receiver: stall on a pattern that changes mode at random intervals.
	initial begin
		stall_mode_t mode;
		out_stall <= 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 2));
			repeat ($urandom_range(50, 300)) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
					default:      out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic last);
		pace();
		in_valid    <= 1'b1;
		pos_x       <= x;
		pos_y       <= y;
		last_vertex <= last;
		do @(posedge clk); while (in_stall);
		sb.note_vertex(x, y, last);
		items_sent++;
	endtask

	function automatic logic [31:0] pick_coord(axis_mode_t mode, logic [31:0] base);
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		case (mode)
			AXIS_FULL:   return $urandom;
			AXIS_NARROW: return base + $urandom_range(0, 511) - 256;
			default:     return base;
		endcase
	endfunction

	task automatic send_mesh(int n);
		axis_mode_t  mx;
		axis_mode_t  my;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] x;
		logic [31:0] y;
		mx = axis_mode_t'($urandom_range(0, 5) == 0 ? AXIS_FLAT : $urandom_range(0, 1));
		my = axis_mode_t'($urandom_range(0, 5) == 0 ? AXIS_FLAT : $urandom_range(0, 1));
		bx = $urandom;
		by = $urandom;
		for (int i = 0; i < n; i++) begin
			x = (mx == AXIS_FLAT) ? bx : pick_coord(mx, bx);
			y = (my == AXIS_FLAT) ? by : pick_coord(my, by);
			send_vertex(x, y, i == n - 1);
		end
	endtask

	initial begin
		int mesh_len;
		int k;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		pos_x       <= '0;
		pos_y       <= '0;
		last_vertex <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex: both axes flat
		send_vertex(32'sd0, 32'sd0, 1'b1);
		// full signed range on both axes
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_vertex(32'sd0, -32'sd1, 1'b1);
		// flat height
		send_vertex(32'sd1, 32'sd5, 1'b0);
		send_vertex(32'sd2, 32'sd5, 1'b0);
		send_vertex(32'sd3, 32'sd5, 1'b1);
		// flat width
		send_vertex(32'sd7, -32'sd3, 1'b0);
		send_vertex(32'sd7, 32'sd9, 1'b1);
		// rounding with mixed signs and large extents
		send_vertex(-32'sd1, 32'sd0, 1'b0);
		send_vertex(32'sd0, 32'sd2, 1'b0);
		send_vertex(32'sd1, 32'sd1, 1'b0);
		send_vertex(-32'sd100, 32'sd200, 1'b0);
		send_vertex(32'sd300, -32'sd400, 1'b0);
		send_vertex(32'h5555_5555, 32'haaaa_aaaa, 1'b1);

		k = 0;
		while (items_sent < ITEMS) begin
			case (k)
				2:       mesh_len = CAP + 2;
				5:       mesh_len = CAP;
				8:       mesh_len = CAP + 1;
				default: mesh_len = $urandom_range(1, 10);
			endcase
			send_mesh(mesh_len);
			k++;
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
